/* rtl/assert_macros.svh */
// Assertion helpers, compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/gem_pkg.sv */
package gem_pkg;

    localparam int STAMP_W = 63;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_FAULT  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_RISE = 2'd1,
        MODE_FALL = 2'd2,
        MODE_BOTH = 2'd3
    } t_mode;

    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_FULL  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_ADD_WR,
        ST_ERR,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_UPD,
        ST_EMIT0,
        ST_EMIT1
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_next;
        logic hit;
        logic shift_init;
        logic shift_wr;
        logic shrink;
        logic add_wr;
        logic upd;
        logic out_err;
        logic out_ev0;
        logic out_ev1;
    } t_cmd;

    typedef struct packed {
        t_action act;
        logic    empty;
        logic    full;
        logic    match;
        logic    scan_last;
        logic    shift_done;
        logic    ev_any;
        logic    ev_two;
        logic    out_free;
    } t_sts;

endpackage

/* rtl/gem_ram.sv */
module gem_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/gem_ctrl.sv */
module gem_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  gem_pkg::t_sts i_sts,
    output gem_pkg::t_cmd o_cmd
);

    import gem_pkg::*;

    t_state r_state;
    t_state n_state;
    t_state miss_state;

    // where to go once the scan has found no entry for the pin
    always_comb begin
        if (i_sts.act == ACT_ADD) begin
            miss_state = i_sts.full ? ST_ERR : ST_ADD_WR;
        end else begin
            miss_state = ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                n_state = i_sts.empty ? miss_state : ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (i_sts.match) begin
                    o_cmd.hit = 1'b1;
                    unique case (i_sts.act)
                        ACT_ADD:    n_state = ST_ADD_WR;
                        ACT_UPDATE: n_state = ST_UPD;
                        default: begin
                            o_cmd.shift_init = 1'b1;
                            n_state          = ST_SHIFT_RD;
                        end
                    endcase
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = i_sts.scan_last ? miss_state : ST_SCAN_RD;
                end
            end
            ST_ADD_WR: begin
                o_cmd.add_wr = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.out_err = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_SHIFT_RD: begin
                if (i_sts.shift_done) begin
                    o_cmd.shrink = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    n_state = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                n_state        = ST_SHIFT_RD;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = i_sts.ev_any ? ST_EMIT0 : ST_IDLE;
            end
            ST_EMIT0: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ev0 = 1'b1;
                    n_state       = i_sts.ev_two ? ST_EMIT1 : ST_IDLE;
                end
            end
            ST_EMIT1: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ev1 = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/gem_dp.sv */
module gem_dp #(
    parameter int TABLE_SLOTS = 32,
    parameter int PIN_BITS    = 10,
    localparam int AW         = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1,
    localparam int EW         = PIN_BITS + 5,
    localparam int IN_TDW     = ((PIN_BITS + 67 + 7) / 8) * 8,
    localparam int OUT_TDW    = ((PIN_BITS + 64 + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [IN_TDW-1:0]  i_s_axis_tdata,
    input  logic [1:0]         i_s_axis_tuser,
    input  gem_pkg::t_cmd      i_cmd,
    output gem_pkg::t_sts      o_sts,
    output logic               o_ram_we,
    output logic [AW-1:0]      o_ram_waddr,
    output logic [EW-1:0]      o_ram_wdata,
    output logic [AW-1:0]      o_ram_raddr,
    input  logic [EW-1:0]      i_ram_rdata,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [OUT_TDW-1:0] o_m_axis_tdata,
    output logic               o_m_axis_tuser,
    output logic               o_m_axis_tlast
);

    import gem_pkg::*;

    localparam int CW = $clog2(TABLE_SLOTS + 1);

    // item latched at accept
    t_action               r_act;
    logic [PIN_BITS-1:0]   r_pin;
    logic [1:0]            r_mode;
    logic                  r_sup;
    logic                  r_lvl;
    logic [STAMP_W-1:0]    r_stamp;

    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         r_count;
    logic [EW-1:0]         r_ent;

    // output beat
    logic                  r_m_valid;
    logic                  r_m_kind;
    logic [PIN_BITS-1:0]   r_m_pin;
    logic                  r_m_lvl;
    logic [STAMP_W-1:0]    r_m_stamp;
    logic                  r_m_last;

    t_action               in_act;
    logic [1:0]            in_mode;
    t_mode                 e_mode;
    logic                  e_sup;
    logic                  e_known;
    logic                  e_lvl;
    logic                  ev_new;
    logic                  ev_any;
    logic                  ev_two;
    logic                  ev0_lvl;
    logic                  upd_wb;
    logic                  out_free;
    logic                  out_load;

    assign in_act  = t_action'(i_s_axis_tuser);
    assign in_mode = i_s_axis_tdata[PIN_BITS+1:PIN_BITS];

    // entry layout: pin, mode, suppress, known, level (level in bit 0)
    assign e_mode  = t_mode'(r_ent[4:3]);
    assign e_sup   = r_ent[2];
    assign e_known = r_ent[1];
    assign e_lvl   = r_ent[0];
    assign ev_new  = !e_known || (e_lvl != r_lvl);

    always_comb begin
        ev_any  = 1'b0;
        ev_two  = 1'b0;
        ev0_lvl = 1'b0;
        upd_wb  = 1'b0;
        unique case (e_mode)
            MODE_RISE: begin
                ev_any  = r_lvl || !e_sup;
                ev0_lvl = 1'b1;
            end
            MODE_FALL: begin
                ev_any  = !r_lvl || !e_sup;
                ev0_lvl = 1'b0;
            end
            MODE_BOTH: begin
                upd_wb  = ev_new;
                ev_any  = ev_new || !e_sup;
                ev_two  = !ev_new && !e_sup;
                ev0_lvl = ev_new ? r_lvl : !r_lvl;
            end
            default: begin
                ev_any = 1'b0;
            end
        endcase
    end

    assign out_free = !r_m_valid || i_m_axis_tready;
    assign out_load = i_cmd.out_err || i_cmd.out_ev0 || i_cmd.out_ev1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.scan_next || i_cmd.shift_init || i_cmd.shift_wr) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.add_wr && (r_idx == r_count)) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.shrink) begin
                r_count <= r_count - CW'(1);
            end
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            // add with mode none is a remove
            r_act   <= (in_act == ACT_ADD && in_mode == MODE_NONE) ? ACT_REMOVE : in_act;
            r_pin   <= i_s_axis_tdata[PIN_BITS-1:0];
            r_mode  <= in_mode;
            r_sup   <= i_s_axis_tdata[PIN_BITS+2];
            r_lvl   <= i_s_axis_tdata[PIN_BITS+3];
            r_stamp <= i_s_axis_tdata[PIN_BITS+66:PIN_BITS+4];
        end
        if (i_cmd.hit) begin
            r_ent <= i_ram_rdata;
        end
        if (i_cmd.out_err) begin
            r_m_kind  <= KIND_FULL;
            r_m_pin   <= r_pin;
            r_m_lvl   <= 1'b0;
            r_m_stamp <= '0;
            r_m_last  <= 1'b1;
        end else if (i_cmd.out_ev0) begin
            r_m_kind  <= KIND_EVENT;
            r_m_pin   <= r_pin;
            r_m_lvl   <= ev0_lvl;
            r_m_stamp <= r_stamp;
            r_m_last  <= !ev_two;
        end else if (i_cmd.out_ev1) begin
            r_m_kind  <= KIND_EVENT;
            r_m_pin   <= r_pin;
            r_m_lvl   <= r_lvl;
            r_m_stamp <= r_stamp;
            r_m_last  <= 1'b1;
        end
    end

    assign o_ram_raddr = r_idx[AW-1:0];
    assign o_ram_we    = i_cmd.add_wr || i_cmd.shift_wr || (i_cmd.upd && upd_wb);

    always_comb begin
        o_ram_waddr = r_idx[AW-1:0];
        o_ram_wdata = {r_pin, r_mode, r_sup, 1'b0, 1'b0};
        if (i_cmd.shift_wr) begin
            o_ram_waddr = AW'(r_idx - CW'(1));
            o_ram_wdata = i_ram_rdata;
        end else if (i_cmd.upd) begin
            o_ram_wdata = {r_ent[EW-1:1], r_lvl} | EW'(2);
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.act        = r_act;
        o_sts.empty      = (r_count == '0);
        o_sts.full       = (r_count == CW'(TABLE_SLOTS));
        o_sts.match      = (i_ram_rdata[EW-1:5] == r_pin);
        o_sts.scan_last  = ((r_idx + CW'(1)) >= r_count);
        o_sts.shift_done = (r_idx >= r_count);
        o_sts.ev_any     = ev_any;
        o_sts.ev_two     = ev_two;
        o_sts.out_free   = out_free;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = OUT_TDW'({r_m_stamp, r_m_lvl, r_m_pin});
    assign o_m_axis_tuser  = r_m_kind;
    assign o_m_axis_tlast  = r_m_last;

endmodule

/* rtl/gpio_edge_event_monitor.sv */
// Pin watch table with edge event reporting. Each input beat adds or replaces a
// listener, removes one, reports a pin fault (also a removal) or carries a
// sampled level; level beats on watched pins give zero, one or two timestamped
// event beats, and an add of a new pin to a full table gives one error beat.
// Entries live in a single-port-read RAM, packed from slot 0, with a fill count
// as the valid mark. An item is accepted, then the table is scanned slot by
// slot, a read state then a check state per slot as the RAM read is registered;
// an add then writes its entry, a removal shifts each later entry down one slot
// (a read, then a write) and shrinks the count, and an update may write back
// the entry, then loads each event beat once the output register is free, so
// output stalls hold it; a new item is taken as soon as its predecessor's result
// beats sit in the output register.
module gpio_edge_event_monitor #(
    parameter int TABLE_SLOTS = 32,
    parameter int PIN_BITS    = 10,
    localparam int IN_TDW     = ((PIN_BITS + 67 + 7) / 8) * 8,
    localparam int OUT_TDW    = ((PIN_BITS + 64 + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // pin, edge_mode, suppress, level, stamp (zero padded)
    input  logic [IN_TDW-1:0]  i_s_axis_tdata,
    // action
    input  logic [1:0]         i_s_axis_tuser,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // event_pin, event_level, event_stamp (zero padded)
    output logic [OUT_TDW-1:0] o_m_axis_tdata,
    // result_kind
    output logic               o_m_axis_tuser,
    output logic               o_m_axis_tlast
);

    import gem_pkg::*;

    localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int EW = PIN_BITS + 5;

    t_cmd          cmd;
    t_sts          sts;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    gem_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    gem_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .PIN_BITS    (PIN_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_ram_we        (ram_we),
        .o_ram_waddr     (ram_waddr),
        .o_ram_wdata     (ram_wdata),
        .o_ram_raddr     (ram_raddr),
        .i_ram_rdata     (ram_rdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    gem_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_one_beat_load, i_clk, i_rst_n, $onehot0({cmd.out_err, cmd.out_ev0, cmd.out_ev1}), "more than one result beat loaded")
    `ASSERT_IMPLIES(a_load_when_free, i_clk, i_rst_n, cmd.out_err || cmd.out_ev0 || cmd.out_ev1, sts.out_free, "result beat overwrites a pending beat")
    `ASSERT_NEXT(a_pair_follows, i_clk, i_rst_n, o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast, o_m_axis_tvalid, "second event beat does not follow the first")
    `ASSERT_IMPLIES(a_err_is_last, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser == KIND_FULL), o_m_axis_tlast, "table-full beat not marked last")

endmodule
